FILE: design/orbit_guidance_step_defines.svh
// Assertion macros shared by the orbit guidance RTL
`ifndef ORBIT_GUIDANCE_STEP_DEFINES_SVH
`define ORBIT_GUIDANCE_STEP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define OGS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("orbit guidance assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define OGS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("orbit guidance assertion failed");

`endif

FILE: design/ogs_pkg.sv
// Types, constants and helper functions of the orbit guidance block
`default_nettype none

package ogs_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int STICK_SHIFT  = 30 - FRAC_BITS;
    localparam int QUOT_W       = FRAC_BITS + 1;
    localparam int UNIT_W       = FRAC_BITS + 2;
    localparam int SQRT_STEPS   = 32;
    localparam int CNT_W        = 6;
    localparam int MUL_A_W      = 35;
    localparam int MUL_B_W      = 32;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    localparam logic [30:0] RST_RMIN   = 31'(64'd5 << FRAC_BITS);
    localparam logic [30:0] RST_RMAX   = 31'(64'd50 << FRAC_BITS);
    localparam logic [30:0] RST_VLIM   = 31'(64'd10 << FRAC_BITS);
    localparam logic [30:0] RST_RFLOOR = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] RST_RCEIL  = 31'(64'd20 << FRAC_BITS);
    localparam logic [30:0] RST_VBOUND = 31'(64'd7 << FRAC_BITS);
    localparam logic [30:0] RST_R0     = 31'(64'd1 << FRAC_BITS);
    localparam logic [31:0] RST_V0     = 32'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [1:0] {
        CMD_ACTIVATE = 2'd0,
        CMD_APPLY    = 2'd1,
        CMD_UPDATE   = 2'd2,
        CMD_SPARE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_RMIN   = 3'd0,
        REG_RMAX   = 3'd1,
        REG_VLIM   = 3'd2,
        REG_RFLOOR = 3'd3,
        REG_RCEIL  = 3'd4,
        REG_VBOUND = 3'd5,
        REG_R0     = 3'd6,
        REG_V0     = 3'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_ST_R, S_ST_V, S_ST_A, S_OFFS, S_SQX, S_SQY, S_SQ0, S_SQRT,
        S_DIV_INIT, S_DIV, S_M1, S_M2, S_M3, S_M4, S_M5, S_COR, S_DONE
    } t_state;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    // arctan(2^-i) in 1/2^32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] t;
        unique case (idx)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
        logic [31:0] r;
        if (v > $signed(MUL_P_W'(32'h7FFFFFFF))) begin
            r = 32'h7FFFFFFF;
        end else if (v < -$signed(MUL_P_W'(32'h80000000))) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/orbit_guidance_step.sv
// Orbit guidance top level: sequencer around one multiplier, root, divider and CORDIC
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     command, position, sticks, times
//   result    out        o_out_valid / i_out_ready   accepted, velocity, altitude, heading
//   config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// An update tick loads the output register after these steps (a zero offset skips both
// divisions): the set-up states ST_R to SQ0, the 32-step square root, two 17-step
// divisions with a set-up state each, the multiply states M1 to M5, 16 CORDIC steps, hand-off.
// Activate, apply and unused codes skip to the hand-off that loads the output register.
// One item at a time; the next can be taken once the result sits in the output
// register, and a stalled result holds the block in its final state.
// Reset is synchronous, active low; it loads the register defaults and clears the orbit.
`default_nettype none

`include "orbit_guidance_step_defines.svh"

module orbit_guidance_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_stick_radius,
    input  wire logic signed [15:0] i_stick_speed,
    input  wire logic signed [15:0] i_stick_alt,
    input  wire logic [15:0]        i_step_time,
    input  wire logic signed [31:0] i_cmd_radius,
    input  wire logic signed [31:0] i_cmd_speed,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_accepted,
    output logic signed [31:0]      o_vel_north,
    output logic signed [31:0]      o_vel_east,
    output logic signed [31:0]      o_alt_setpoint,
    output logic [15:0]             o_heading,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int F  = ogs_pkg::FRAC_BITS;
    localparam int PW = ogs_pkg::MUL_P_W;
    localparam int CW = ogs_pkg::CNT_W;

    ogs_pkg::t_state r_state, n_state;

    // configuration
    logic [30:0]        r_cfg_rmin, r_cfg_rmax, r_cfg_vlim, r_cfg_rfloor;
    logic [30:0]        r_cfg_rceil, r_cfg_vbound, r_cfg_r0;
    logic signed [31:0] r_cfg_v0;

    // orbit state
    logic signed [31:0] r_radius, r_speed, r_alt, r_cn, r_ce;

    // latched item and work registers
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_sr, r_sv, r_sa;
    logic [15:0]        r_dt;
    logic               r_upd, r_acc;
    logic signed [31:0] r_ex, r_ey;
    logic               r_k;
    logic signed [PW-1:0] r_mac;
    logic [63:0]        r_rem, r_root, r_bit;
    logic [CW-1:0]      r_cnt;
    logic               r_sel, r_neg;
    logic [31:0]        r_da, r_drem;
    logic [ogs_pkg::QUOT_W-1:0] r_quot;
    logic signed [ogs_pkg::UNIT_W-1:0] r_ux, r_uy;
    logic signed [34:0] r_rad;
    logic signed [31:0] r_vn, r_ve;
    logic signed [34:0] r_cx, r_cy;
    logic [31:0]        r_z;

    // output register
    logic               r_out_valid, r_out_acc;
    logic signed [31:0] r_out_vn, r_out_ve, r_out_alt;
    logic [15:0]        r_out_hd;

    logic               w_in_fire, w_out_load;
    ogs_pkg::t_mul_req  w_mul_req;
    logic signed [PW-1:0] w_prod, w_dlt;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == ogs_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    ogs_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    assign w_dlt = w_prod >>> ogs_pkg::STICK_SHIFT;

    // datapath combinational terms
    logic signed [32:0] w_act_cn, w_cv33, w_av;
    logic               w_cmd_ok;
    logic signed [33:0] w_rsum, w_vsum, w_asum, w_vb;
    logic signed [31:0] w_rnew, w_vnew;
    logic signed [32:0] w_dx, w_dy;
    logic               w_big;
    logic [63:0]        w_trial;
    logic               w_sq_ge;
    logic [32:0]        w_rem2;
    logic               w_div_ge;
    logic signed [31:0] w_e;
    logic [31:0]        w_ea;
    logic signed [ogs_pkg::UNIT_W-1:0] w_q;
    logic signed [34:0] w_norm, w_sx, w_sy;
    logic [31:0]        w_atan, w_zfin;

    always_comb begin
        w_act_cn = $signed({i_pos_x[31], i_pos_x}) - $signed({2'b00, r_cfg_r0});
        w_cv33   = $signed({i_cmd_speed[31], i_cmd_speed});
        w_av     = w_cv33[32] ? -w_cv33 : w_cv33;
        w_cmd_ok = (i_cmd_radius >= $signed({1'b0, r_cfg_rmin}))
                && (i_cmd_radius <= $signed({1'b0, r_cfg_rmax}))
                && ($unsigned(w_av) < {2'b00, r_cfg_vlim});

        w_rsum = $signed({{2{r_radius[31]}}, r_radius}) + w_dlt[33:0];
        if (w_rsum < $signed({3'b000, r_cfg_rfloor})) begin
            w_rnew = $signed({1'b0, r_cfg_rfloor});
        end else if (w_rsum > $signed({3'b000, r_cfg_rceil})) begin
            w_rnew = $signed({1'b0, r_cfg_rceil});
        end else begin
            w_rnew = w_rsum[31:0];
        end

        w_vb   = $signed({3'b000, r_cfg_vbound});
        w_vsum = $signed({{2{r_speed[31]}}, r_speed}) - w_dlt[33:0];
        if (w_vsum < -w_vb) begin
            w_vnew = 32'(-w_vb);
        end else if (w_vsum > w_vb) begin
            w_vnew = w_vb[31:0];
        end else begin
            w_vnew = w_vsum[31:0];
        end
        w_asum = $signed({{2{r_alt[31]}}, r_alt}) + w_dlt[33:0];

        w_dx  = $signed({r_px[31], r_px}) - $signed({r_cn[31], r_cn});
        w_dy  = $signed({r_py[31], r_py}) - $signed({r_ce[31], r_ce});
        w_big = (w_dx > 33'sd2147483647) || (w_dx < -33'sd2147483647)
             || (w_dy > 33'sd2147483647) || (w_dy < -33'sd2147483647);

        w_trial = r_root + r_bit;
        w_sq_ge = r_rem >= w_trial;

        w_rem2   = {r_drem, (r_cnt == CW'(F)) ? r_da[0] : 1'b0};
        w_div_ge = w_rem2 >= {1'b0, r_root[31:0]};
        w_e      = r_sel ? r_ey : r_ex;
        w_ea     = w_e[31] ? 32'(-w_e) : w_e;
        w_q      = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
        w_norm   = r_k ? $signed({2'b00, r_root[31:0], 1'b0})
                       : $signed({3'b000, r_root[31:0]});

        w_sx   = r_cx >>> r_cnt;
        w_sy   = r_cy >>> r_cnt;
        w_atan = ogs_pkg::atan_turn(r_cnt[4:0]);
        w_zfin = r_z + 32'h80008000;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ogs_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (ogs_pkg::t_cmd'(i_command) == ogs_pkg::CMD_UPDATE)
                            ? ogs_pkg::S_ST_R : ogs_pkg::S_DONE;
                end
            end
            ogs_pkg::S_ST_R: n_state = ogs_pkg::S_ST_V;
            ogs_pkg::S_ST_V: n_state = ogs_pkg::S_ST_A;
            ogs_pkg::S_ST_A: n_state = ogs_pkg::S_OFFS;
            ogs_pkg::S_OFFS: n_state = ogs_pkg::S_SQX;
            ogs_pkg::S_SQX:  n_state = ogs_pkg::S_SQY;
            ogs_pkg::S_SQY:  n_state = ogs_pkg::S_SQ0;
            ogs_pkg::S_SQ0:  n_state = ogs_pkg::S_SQRT;
            ogs_pkg::S_SQRT: begin
                if (r_cnt == CW'(ogs_pkg::SQRT_STEPS - 1)) n_state = ogs_pkg::S_DIV_INIT;
            end
            ogs_pkg::S_DIV_INIT: begin
                n_state = (r_root == 64'd0) ? ogs_pkg::S_M1 : ogs_pkg::S_DIV;
            end
            ogs_pkg::S_DIV: begin
                if (r_cnt == '0) n_state = r_sel ? ogs_pkg::S_M1 : ogs_pkg::S_DIV_INIT;
            end
            ogs_pkg::S_M1: n_state = ogs_pkg::S_M2;
            ogs_pkg::S_M2: n_state = ogs_pkg::S_M3;
            ogs_pkg::S_M3: n_state = ogs_pkg::S_M4;
            ogs_pkg::S_M4: n_state = ogs_pkg::S_M5;
            ogs_pkg::S_M5: n_state = ogs_pkg::S_COR;
            ogs_pkg::S_COR: begin
                if (r_cnt == CW'(ogs_pkg::CORDIC_STEPS - 1)) n_state = ogs_pkg::S_DONE;
            end
            ogs_pkg::S_DONE: begin
                if (w_out_load) n_state = ogs_pkg::S_IDLE;
            end
            default: n_state = ogs_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: input ready and multiplier operands
    always_comb begin
        o_in_ready  = (r_state == ogs_pkg::S_IDLE);
        w_mul_req.a = '0;
        w_mul_req.b = '0;
        unique case (r_state)
            ogs_pkg::S_ST_R: begin
                w_mul_req.a = 35'(r_sr);
                w_mul_req.b = $signed({16'h0, r_dt});
            end
            ogs_pkg::S_ST_V: begin
                w_mul_req.a = 35'(r_sv);
                w_mul_req.b = $signed({16'h0, r_dt});
            end
            ogs_pkg::S_ST_A: begin
                w_mul_req.a = 35'(r_sa);
                w_mul_req.b = $signed({16'h0, r_dt});
            end
            ogs_pkg::S_SQX: begin
                w_mul_req.a = 35'(r_ex);
                w_mul_req.b = r_ex;
            end
            ogs_pkg::S_SQY: begin
                w_mul_req.a = 35'(r_ey);
                w_mul_req.b = r_ey;
            end
            ogs_pkg::S_M1: begin
                // the y quotient is still on the divider output here
                w_mul_req.a = 35'(r_speed);
                w_mul_req.b = r_sel ? 32'(w_q) : 32'(r_uy);
            end
            ogs_pkg::S_M2: begin
                w_mul_req.a = r_rad;
                w_mul_req.b = 32'(r_ux);
            end
            ogs_pkg::S_M3: begin
                w_mul_req.a = r_rad;
                w_mul_req.b = 32'(r_uy);
            end
            ogs_pkg::S_M4: begin
                w_mul_req.a = 35'(r_speed);
                w_mul_req.b = 32'(r_ux);
            end
            default: begin
                w_mul_req.a = '0;
                w_mul_req.b = '0;
            end
        endcase
    end

    // control, configuration and orbit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ogs_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_cfg_rmin   <= ogs_pkg::RST_RMIN;
            r_cfg_rmax   <= ogs_pkg::RST_RMAX;
            r_cfg_vlim   <= ogs_pkg::RST_VLIM;
            r_cfg_rfloor <= ogs_pkg::RST_RFLOOR;
            r_cfg_rceil  <= ogs_pkg::RST_RCEIL;
            r_cfg_vbound <= ogs_pkg::RST_VBOUND;
            r_cfg_r0     <= ogs_pkg::RST_R0;
            r_cfg_v0     <= ogs_pkg::RST_V0;
            r_radius     <= '0;
            r_speed      <= '0;
            r_alt        <= '0;
            r_cn         <= '0;
            r_ce         <= '0;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (ogs_pkg::t_reg_idx'(i_cfg_idx))
                    ogs_pkg::REG_RMIN:   r_cfg_rmin   <= i_cfg_data[30:0];
                    ogs_pkg::REG_RMAX:   r_cfg_rmax   <= i_cfg_data[30:0];
                    ogs_pkg::REG_VLIM:   r_cfg_vlim   <= i_cfg_data[30:0];
                    ogs_pkg::REG_RFLOOR: r_cfg_rfloor <= i_cfg_data[30:0];
                    ogs_pkg::REG_RCEIL:  r_cfg_rceil  <= i_cfg_data[30:0];
                    ogs_pkg::REG_VBOUND: r_cfg_vbound <= i_cfg_data[30:0];
                    ogs_pkg::REG_R0:     r_cfg_r0     <= i_cfg_data[30:0];
                    ogs_pkg::REG_V0:     r_cfg_v0     <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            if (w_in_fire) begin
                unique case (ogs_pkg::t_cmd'(i_command))
                    ogs_pkg::CMD_ACTIVATE: begin
                        r_radius <= $signed({1'b0, r_cfg_r0});
                        r_speed  <= r_cfg_v0;
                        r_alt    <= i_pos_z;
                        r_cn     <= (w_act_cn < -33'sd2147483648) ? 32'sh80000000
                                                                  : w_act_cn[31:0];
                        r_ce     <= i_pos_y;
                    end
                    ogs_pkg::CMD_APPLY: begin
                        if (w_cmd_ok) begin
                            r_radius <= i_cmd_radius;
                            r_speed  <= i_cmd_speed;
                        end
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                ogs_pkg::S_ST_V: r_radius <= w_rnew;
                ogs_pkg::S_ST_A: r_speed  <= w_vnew;
                ogs_pkg::S_OFFS: r_alt    <= ogs_pkg::sat32(PW'(w_asum));
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_sr  <= i_stick_radius;
            r_sv  <= i_stick_speed;
            r_sa  <= i_stick_alt;
            r_dt  <= i_step_time;
            r_upd <= (ogs_pkg::t_cmd'(i_command) == ogs_pkg::CMD_UPDATE);
            r_acc <= (ogs_pkg::t_cmd'(i_command) == ogs_pkg::CMD_ACTIVATE)
                  || (ogs_pkg::t_cmd'(i_command) == ogs_pkg::CMD_UPDATE)
                  || ((ogs_pkg::t_cmd'(i_command) == ogs_pkg::CMD_APPLY) && w_cmd_ok);
            r_vn  <= '0;
            r_ve  <= '0;
        end

        unique case (r_state)
            ogs_pkg::S_OFFS: begin
                // halve an offset too wide for the square and double the norm back later
                r_k  <= w_big;
                r_ex <= w_big ? w_dx[32:1] : w_dx[31:0];
                r_ey <= w_big ? w_dy[32:1] : w_dy[31:0];
            end
            ogs_pkg::S_SQY: r_mac <= w_prod;
            ogs_pkg::S_SQ0: begin
                r_rem  <= r_mac[63:0] + w_prod[63:0];
                r_root <= '0;
                r_bit  <= 64'h4000000000000000;
                r_cnt  <= '0;
                r_sel  <= 1'b0;
            end
            ogs_pkg::S_SQRT: begin
                if (w_sq_ge) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            ogs_pkg::S_DIV_INIT: begin
                if (!r_sel) begin
                    r_rad <= $signed({{3{r_radius[31]}}, r_radius}) - w_norm;
                end
                if (r_root == 64'd0) begin
                    r_ux <= '0;
                    r_uy <= '0;
                end
                r_da   <= w_ea;
                r_drem <= w_ea >> 1;
                r_neg  <= w_e[31];
                r_quot <= '0;
                r_cnt  <= CW'(F);
            end
            ogs_pkg::S_DIV: begin
                if (w_div_ge) begin
                    r_drem <= 32'(w_rem2 - {1'b0, r_root[31:0]});
                end else begin
                    r_drem <= w_rem2[31:0];
                end
                r_quot <= {r_quot[ogs_pkg::QUOT_W-2:0], w_div_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_sel <= 1'b1;
                end
            end
            ogs_pkg::S_M1: begin
                if (r_sel) begin
                    r_uy <= w_q;
                end
            end
            ogs_pkg::S_M2: r_mac <= w_prod;
            ogs_pkg::S_M3: r_vn  <= ogs_pkg::sat32((r_mac + w_prod) >>> F);
            ogs_pkg::S_M4: r_mac <= w_prod;
            ogs_pkg::S_M5: begin
                r_ve <= ogs_pkg::sat32((r_mac - w_prod) >>> F);
                // left half plane: turn by a half turn first
                if (r_ex[31]) begin
                    r_cx <= -35'(r_ex);
                    r_cy <= -35'(r_ey);
                    r_z  <= 32'h80000000;
                end else begin
                    r_cx <= 35'(r_ex);
                    r_cy <= 35'(r_ey);
                    r_z  <= '0;
                end
                r_cnt <= '0;
            end
            ogs_pkg::S_COR: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_sy;
                    r_cy <= r_cy - w_sx;
                    r_z  <= r_z + w_atan;
                end else if (r_cy < 0) begin
                    r_cx <= r_cx - w_sy;
                    r_cy <= r_cy + w_sx;
                    r_z  <= r_z - w_atan;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase

        // the x quotient is ready as the y division starts
        if ((r_state == ogs_pkg::S_DIV_INIT) && r_sel && (r_root != 64'd0)) begin
            r_ux <= w_q;
        end

        if (w_out_load) begin
            r_out_acc <= r_acc;
            r_out_vn  <= r_vn;
            r_out_ve  <= r_ve;
            r_out_alt <= r_alt;
            r_out_hd  <= r_upd ? w_zfin[31:16] : 16'h0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_acc;
    assign o_vel_north    = r_out_vn;
    assign o_vel_east     = r_out_ve;
    assign o_alt_setpoint = r_out_alt;
    assign o_heading      = r_out_hd;

    `OGS_ASSERT_NXT(a_busy_after_accept, w_in_fire, !o_in_ready)
    `OGS_ASSERT_IMP(a_root_bit_onehot, r_state == ogs_pkg::S_SQRT, $onehot(r_bit))
    `OGS_ASSERT_IMP(a_div_rem_below, r_state == ogs_pkg::S_DIV, r_drem < r_root[31:0])
    `OGS_ASSERT_IMP(a_reject_is_quiet, o_out_valid && !o_accepted,
        (o_vel_north == 32'sd0) && (o_vel_east == 32'sd0) && (o_heading == 16'h0))

endmodule

`default_nettype wire

FILE: design/ogs_mul.sv
// Shared signed multiplier with registered product
`default_nettype none

module ogs_mul (
    input  wire logic                                   i_clk,
    input  wire ogs_pkg::t_mul_req                      i_req,
    output logic signed [ogs_pkg::MUL_P_W-1:0]          o_prod
);

    logic signed [ogs_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: tb/orbit_guidance_step_tb.sv
// Self-checking testbench for the orbit guidance step: directed table, then random orbits
`default_nettype none

module orbit_guidance_step_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               acc;
        logic signed [31:0] vn;
        logic signed [31:0] ve;
        logic signed [31:0] alt;
        logic [15:0]        hd;
    } t_guid;

    typedef struct packed {
        ogs_pkg::t_cmd      cmd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] sr;
        logic signed [15:0] sv;
        logic signed [15:0] sa;
        logic [15:0]        dt;
        logic signed [31:0] cr;
        logic signed [31:0] cv;
    } t_item;

    typedef struct packed {
        t_item item;
        logic  typed;
        t_guid want;
    } t_row;

    localparam int NUM_ROWS = 16;
    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 172;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_command = ogs_pkg::CMD_SPARE;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic signed [15:0] i_stick_radius = '0;
    logic signed [15:0] i_stick_speed = '0;
    logic signed [15:0] i_stick_alt = '0;
    logic [15:0]        i_step_time = '0;
    logic signed [31:0] i_cmd_radius = '0;
    logic signed [31:0] i_cmd_speed = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_accepted;
    logic signed [31:0] o_vel_north;
    logic signed [31:0] o_vel_east;
    logic signed [31:0] o_alt_setpoint;
    logic [15:0]        o_heading;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = ogs_pkg::REG_RMIN;
    logic [31:0]        i_cfg_data = '0;

    orbit_guidance_step u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // guidance state and register copy
    longint lim_rmin, lim_rmax, lim_vlim, clamp_floor, clamp_ceil, clamp_vbound;
    longint act_radius, act_speed;
    int     radius_q, speed_q, alt_q, ctr_north, ctr_east;

    t_guid  pending_guid[$];
    int     err_count = 0;
    longint cyc = 0;

    always @(posedge i_clk) cyc <= cyc + 1;

    // no idling in this window
    function automatic bit calm();
        return cyc > 30000 && cyc < 60000;
    endfunction

    function automatic longint clip32(longint x);
        if (x > longint'(S32_MAX)) return longint'(S32_MAX);
        if (x < longint'(S32_MIN)) return longint'(S32_MIN);
        return x;
    endfunction

    function automatic longint stick_rate(longint stick, longint dt);
        return (stick * dt) >>> (30 - ogs_pkg::FRAC_BITS);
    endfunction

    function automatic longint root64(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [15:0] bearing(longint x, longint y);
        bit [31:0] z, zr;
        longint nx, ny;
        bit [31:0] tab [24] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        z = 0;
        if (x == 0 && y == 0) return 16'h8000;
        // turn a left-half-plane vector by a half turn first
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < ogs_pkg::CORDIC_STEPS && i < 24; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + tab[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - tab[i];
            end
            x = nx;
            y = ny;
        end
        zr = z + 32'h80000000 + 32'h8000;
        return zr[31:16];
    endfunction

    function automatic void load_reg(ogs_pkg::t_reg_idx idx, logic [31:0] val);
        longint u;
        u = longint'(val[30:0]);
        case (idx)
            ogs_pkg::REG_RMIN:   lim_rmin = u;
            ogs_pkg::REG_RMAX:   lim_rmax = u;
            ogs_pkg::REG_VLIM:   lim_vlim = u;
            ogs_pkg::REG_RFLOOR: clamp_floor = u;
            ogs_pkg::REG_RCEIL:  clamp_ceil = u;
            ogs_pkg::REG_VBOUND: clamp_vbound = u;
            ogs_pkg::REG_R0:     act_radius = u;
            ogs_pkg::REG_V0:     act_speed = longint'($signed(val));
            default: ;
        endcase
    endfunction

    function automatic t_guid guide(t_item it);
        t_guid  g;
        longint r, v, dx, dy, ex, ey, ns, norm, ux, uy, rad, av, cr, cv;
        bit     halved;
        g = '0;
        cr = longint'(it.cr);
        cv = longint'(it.cv);
        case (it.cmd)
            ogs_pkg::CMD_ACTIVATE: begin
                radius_q = int'(act_radius);
                speed_q = int'(act_speed);
                alt_q = it.pz;
                ctr_north = int'(clip32(longint'(it.px) - act_radius));
                ctr_east = it.py;
                g.acc = 1'b1;
            end
            ogs_pkg::CMD_APPLY: begin
                av = cv < 0 ? -cv : cv;
                if (cr >= lim_rmin && cr <= lim_rmax && av < lim_vlim) begin
                    radius_q = it.cr;
                    speed_q = it.cv;
                    g.acc = 1'b1;
                end
            end
            ogs_pkg::CMD_UPDATE: begin
                r = longint'(radius_q) + stick_rate(longint'(it.sr), longint'(it.dt));
                v = longint'(speed_q) - stick_rate(longint'(it.sv), longint'(it.dt));
                if (r < clamp_floor) r = clamp_floor;
                else if (r > clamp_ceil) r = clamp_ceil;
                if (v < -clamp_vbound) v = -clamp_vbound;
                else if (v > clamp_vbound) v = clamp_vbound;
                radius_q = int'(r);
                speed_q = int'(v);
                alt_q = int'(clip32(longint'(alt_q)
                    + stick_rate(longint'(it.sa), longint'(it.dt))));
                dx = longint'(it.px) - longint'(ctr_north);
                dy = longint'(it.py) - longint'(ctr_east);
                ex = dx;
                ey = dy;
                halved = 1'b0;
                // halve an offset that does not fit 32 bits
                if (dx > 64'sh7FFFFFFF || dx < -64'sh7FFFFFFF
                        || dy > 64'sh7FFFFFFF || dy < -64'sh7FFFFFFF) begin
                    ex = dx >>> 1;
                    ey = dy >>> 1;
                    halved = 1'b1;
                end
                ns = root64(64'(ex * ex) + 64'(ey * ey));
                norm = halved ? ns * 2 : ns;
                ux = 0;
                uy = 0;
                if (ns > 0) begin
                    ux = (ex * (64'sd1 <<< ogs_pkg::FRAC_BITS)) / ns;
                    uy = (ey * (64'sd1 <<< ogs_pkg::FRAC_BITS)) / ns;
                end
                rad = r - norm;
                g.vn = 32'(clip32((v * uy + rad * ux) >>> ogs_pkg::FRAC_BITS));
                g.ve = 32'(clip32((-v * ux + rad * uy) >>> ogs_pkg::FRAC_BITS));
                g.hd = bearing(ex, ey);
                g.acc = 1'b1;
            end
            default: ;
        endcase
        g.alt = alt_q;
        return g;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // result side
    always @(posedge i_clk) begin
        t_guid w;
        if (o_out_valid && i_out_ready) begin
            if (pending_guid.size() == 0) begin
                report("result with nothing pending", 1, 0);
            end else begin
                w = pending_guid.pop_front();
                if (o_accepted !== w.acc) report("accepted", o_accepted, w.acc);
                if (o_vel_north !== w.vn) report("vel_north", o_vel_north, w.vn);
                if (o_vel_east !== w.ve) report("vel_east", o_vel_east, w.ve);
                if (o_alt_setpoint !== w.alt) report("alt_setpoint", o_alt_setpoint, w.alt);
                if (o_heading !== w.hd) report("heading", o_heading, w.hd);
            end
        end
        i_out_ready <= calm() || ($urandom_range(99) >= 7);
    end

    task automatic send(t_item it, bit typed, t_guid want);
        t_guid g;
        while (!calm() && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= it.cmd;
        i_pos_x <= it.px;
        i_pos_y <= it.py;
        i_pos_z <= it.pz;
        i_stick_radius <= it.sr;
        i_stick_speed <= it.sv;
        i_stick_alt <= it.sa;
        i_step_time <= it.dt;
        i_cmd_radius <= it.cr;
        i_cmd_speed <= it.cv;
        do @(posedge i_clk); while (!o_in_ready);
        g = guide(it);
        pending_guid.push_back(typed ? want : g);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_guid.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_item mk(ogs_pkg::t_cmd c, int px, int py, int pz, shortint sr,
                                 shortint sv, shortint sa, int dt, int cr, int cv);
        t_item it;
        it.cmd = c;
        it.px = px;
        it.py = py;
        it.pz = pz;
        it.sr = sr;
        it.sv = sv;
        it.sa = sa;
        it.dt = 16'(dt);
        it.cr = cr;
        it.cv = cv;
        return it;
    endfunction

    function automatic shortint rand_stick();
        return shortint'($urandom_range(32768)) - 16'sd16384;
    endfunction

    function automatic t_item rand_item();
        t_item  it;
        int     roll, spread;
        longint lo, hi;
        it = mk(ogs_pkg::CMD_UPDATE, $urandom, $urandom, $urandom, rand_stick(),
                rand_stick(), rand_stick(), $urandom_range(65535), $urandom, $urandom);
        roll = $urandom_range(99);
        if (roll < 8) begin
            it.cmd = ogs_pkg::CMD_ACTIVATE;
            if ($urandom_range(3) != 0) begin
                it.px = $signed($urandom_range(2000000)) - 1000000;
                it.py = $signed($urandom_range(2000000)) - 1000000;
            end
        end else if (roll < 18) begin
            it.cmd = ogs_pkg::CMD_APPLY;
            // mostly inside the limits
            if ($urandom_range(2) != 0 && lim_rmin <= lim_rmax) begin
                lo = lim_rmin;
                hi = lim_rmax;
                it.cr = int'(lo + longint'($urandom) % (hi - lo + 1));
                if (lim_vlim > 0) begin
                    it.cv = int'(longint'($urandom) % lim_vlim);
                    if ($urandom_range(1)) it.cv = -it.cv;
                end
            end
        end else if (roll < 21) begin
            it.cmd = ogs_pkg::CMD_SPARE;
        end else if (roll < 92) begin
            spread = 1 << $urandom_range(23, 8);
            case ($urandom_range(7))
                0: begin
                    it.px = ctr_north;
                    it.py = ctr_east;
                end
                1: it.py = ctr_east;
                2: it.px = ctr_north;
                3: ;
                default: begin
                    it.px = int'(longint'(ctr_north) + $signed($urandom_range(spread))
                                 - spread / 2);
                    it.py = int'(longint'(ctr_east) + $signed($urandom_range(spread))
                                 - spread / 2);
                end
            endcase
            if ($urandom_range(3) == 0) it.dt = $urandom_range(2000);
        end
        return it;
    endfunction

    t_row rows [NUM_ROWS];

    initial begin
        t_guid       g0;
        logic [31:0] regs [8];
        lim_rmin = ogs_pkg::RST_RMIN;
        lim_rmax = ogs_pkg::RST_RMAX;
        lim_vlim = ogs_pkg::RST_VLIM;
        clamp_floor = ogs_pkg::RST_RFLOOR;
        clamp_ceil = ogs_pkg::RST_RCEIL;
        clamp_vbound = ogs_pkg::RST_VBOUND;
        act_radius = ogs_pkg::RST_R0;
        act_speed = longint'($signed(ogs_pkg::RST_V0));
        radius_q = 0;
        speed_q = 0;
        alt_q = 0;
        ctr_north = 0;
        ctr_east = 0;

        // directed: typed expectations only where obvious
        rows = '{default: '0};
        rows[0].item = mk(ogs_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows[0].typed = 1'b1;
        rows[0].want = '{acc: 1'b1, vn: 0, ve: 0, alt: 0, hd: 16'h8000};
        rows[1].item = mk(ogs_pkg::CMD_SPARE, -1, -1, -1, -1, -1, -1, 65535, -1, -1);
        rows[1].typed = 1'b1;
        rows[1].want = '{acc: 1'b0, vn: 0, ve: 0, alt: 0, hd: 0};
        rows[2].item = mk(ogs_pkg::CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, S32_MAX, 0);
        rows[2].typed = 1'b1;
        rows[3].item = mk(ogs_pkg::CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, 5 << 16, -(10 << 16));
        rows[3].typed = 1'b1;
        rows[4].item = mk(ogs_pkg::CMD_ACTIVATE, S32_MIN, S32_MAX, S32_MAX, 0, 0, 0, 0, 0, 0);
        rows[4].typed = 1'b1;
        rows[4].want = '{acc: 1'b1, vn: 0, ve: 0, alt: S32_MAX, hd: 0};
        rows[5].item = mk(ogs_pkg::CMD_UPDATE, S32_MAX, S32_MIN, 0, 16384, 16384, 16384,
                          65535, 0, 0);
        rows[6].item = mk(ogs_pkg::CMD_UPDATE, S32_MAX, S32_MIN, 0, -16384, -16384, -16384,
                          65535, 0, 0);
        rows[7].item = mk(ogs_pkg::CMD_ACTIVATE, 0, 0, S32_MIN, 0, 0, 0, 0, 0, 0);
        rows[8].item = mk(ogs_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, -16384, 65535, 0, 0);
        rows[9].item = mk(ogs_pkg::CMD_UPDATE, -(1 << 16), 0, 0, 0, 0, 0, 100, 0, 0);
        rows[10].item = mk(ogs_pkg::CMD_UPDATE, -(1 << 16), 3 << 16, 0, 0, 0, 0, 100, 0, 0);
        rows[11].item = mk(ogs_pkg::CMD_UPDATE, -(1 << 16), -(3 << 16), 0, 0, 0, 0, 100,
                           0, 0);
        rows[12].item = mk(ogs_pkg::CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, 50 << 16,
                           (10 << 16) - 1);
        rows[13].item = mk(ogs_pkg::CMD_UPDATE, -(4 << 16), 0, 0, 0, 0, 0, 0, 0, 0);
        rows[14].item = mk(ogs_pkg::CMD_APPLY, 0, 0, 0, 0, 0, 0, 0, (5 << 16) - 1, 0);
        rows[15].item = mk(ogs_pkg::CMD_UPDATE, 5 << 16, -(2 << 16), 0, 16384, -16384, 0,
                           65535, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) send(rows[i].item, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: regs = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
                    2: regs = '{$urandom_range(10 << 16), 32'd40 << 16,
                                $urandom_range(20 << 16), $urandom_range(2 << 16),
                                32'd30 << 16, $urandom_range(15 << 16),
                                $urandom_range(25 << 16), $urandom};
                    3: regs = '{32'd40 << 16, 32'd2 << 16, 32'h0, 32'd30 << 16,
                                32'd2 << 16, 32'h0, 32'h0, 32'h7FFFFFFF};
                    4: regs = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom};
                    default: regs = '{32'h80000000 | (5 << 16), 32'd50 << 16,
                                      32'd10 << 16, 32'd1 << 16, 32'd20 << 16,
                                      32'd7 << 16, 32'd1 << 16, 32'hFFFF8000};
                endcase
                for (int r = 0; r < 8; r++) begin
                    i_cfg_we <= 1'b1;
                    i_cfg_idx <= 3'(r);
                    i_cfg_data <= regs[r];
                    @(posedge i_clk);
                    load_reg(ogs_pkg::t_reg_idx'(r), regs[r]);
                end
                i_cfg_we <= 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send(rand_item(), 1'b0, g0);
        end

        drain();
        repeat (120) @(posedge i_clk);
        if (err_count == 0) begin
            $display("orbit_guidance_step: match");
        end else begin
            $display("orbit_guidance_step: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("orbit_guidance_step: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

FILE: orbit_guidance_step.f
+incdir+design
design/ogs_pkg.sv
design/ogs_mul.sv
design/orbit_guidance_step.sv
tb/orbit_guidance_step_tb.sv
